// ===== src/shtl_pkg.sv =====
package shtl_pkg;

	localparam int HASH_W = 32;
	localparam int IDX_W = 8;
	localparam int ROT_W = 5;
	localparam logic [ROT_W-1:0] ROT_STEP = 5'd5;

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_MISSING = 2'd1,
		ST_INSERTED = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// lookup request as it walks the cell row
	typedef struct packed {
		logic valid;
		logic found;
		logic [HASH_W-1:0] hash;
		logic [IDX_W-1:0] idx;
		logic wide;
	} query_t;

	function automatic logic [HASH_W-1:0] rotl32(input logic [HASH_W-1:0] v,
			input logic [ROT_W-1:0] r);
		logic [2*HASH_W-1:0] dbl;
		begin
			dbl = {v, v} << r;
			return dbl[2*HASH_W-1:HASH_W];
		end
	endfunction

endpackage

// ===== src/string_hash_table_lookup.sv =====
// Channel   | Signals                                  | Handshake
// ----------+------------------------------------------+----------------------------------
// command   | action, char_unit, wide, last            | taken on clk when start && !busy
// result    | status, match_index, key_hash, wide_out  | valid for one cycle with done
//
// One key character is taken per cycle while busy is low.
// Insert: result in the cycle after the last character; busy stays low.
// Lookup: the query walks the row of ENTRIES cells, one cell a cycle, and the result
//   is registered once it leaves the last cell; busy is high meanwhile.
// Reset clears the key state and the fill count; the entry store needs no clearing.
// The receiver cannot stall: done is a one-cycle strobe.
module string_hash_table_lookup #(
	parameter int ENTRIES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [15:0] char_unit,
	input logic wide,
	input logic last,
	output logic done,
	output shtl_pkg::status_t status,
	output logic [7:0] match_index,
	output logic [31:0] key_hash,
	output logic wide_out
);
	import shtl_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

	logic accept;
	logic is_key_char;
	logic key_done;
	logic restart;
	logic ins_last;
	logic table_full;
	logic wr_en;
	logic [HASH_W-1:0] hash_now;
	logic [CW-1:0] count_q;
	logic busy_q;
	query_t head;
	query_t chain [ENTRIES+1];
	query_t tail;

	logic done_q;
	status_t status_q;
	logic [IDX_W-1:0] idx_q;
	logic [HASH_W-1:0] khash_q;
	logic wide_q;

	assign accept = start && !busy_q;
	assign is_key_char = (action == ACT_INSERT) || (action == ACT_LOOKUP);
	assign key_done = accept && is_key_char && last;
	// clear drops any partial key as well
	assign restart = key_done || (accept && (action == ACT_CLEAR));
	assign ins_last = key_done && (action == ACT_INSERT);
	assign table_full = (count_q == FULL_COUNT);
	assign wr_en = ins_last && !table_full;

	shtl_hasher u_hasher (
		.clk(clk),
		.arst_n(arst_n),
		.absorb(accept && is_key_char),
		.restart(restart),
		.char_byte(char_unit[7:0]),
		.hash_now(hash_now)
	);

	// lookup query enters the head of the cell row
	always_comb begin
		head = '0;
		head.valid = key_done && (action == ACT_LOOKUP);
		head.hash = hash_now;
		head.wide = wide;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		shtl_cell #(
			.IDX(i),
			.CW(CW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.count(count_q),
			.wr_en(wr_en),
			.wr_idx(count_q),
			.wr_hash(hash_now),
			.q_in(chain[i]),
			.q_out(chain[i+1])
		);
	end

	assign tail = chain[ENTRIES];

	// fill count: writes go to the next free cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (action == ACT_CLEAR)) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	// one lookup in flight at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (head.valid) begin
			busy_q <= 1'b1;
		end else if (tail.valid) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid || ins_last;
		end
	end

	// result payload: lookup tail and insert never coincide (busy blocks input)
	always_ff @(posedge clk) begin
		if (tail.valid) begin
			status_q <= tail.found ? ST_FOUND : ST_MISSING;
			idx_q <= tail.idx;
			khash_q <= tail.hash;
			wide_q <= tail.wide;
		end else if (ins_last) begin
			status_q <= table_full ? ST_FULL : ST_INSERTED;
			idx_q <= table_full ? '0 : IDX_W'(count_q);
			khash_q <= hash_now;
			wide_q <= wide;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign status = status_q;
	assign match_index = idx_q;
	assign key_hash = khash_q;
	assign wide_out = wide_q;

	// query leaving the row always retires the busy flag
	a_tail_frees: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> !busy_q)
		else $error("busy held after lookup completed");

	// a query only travels while the block is busy
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("lookup query outside busy window");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("fill count beyond table size");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == ST_INSERTED)) |-> (count_q != '0))
		else $error("insert reported with empty table");

endmodule

// ===== src/shtl_hasher.sv =====
module shtl_hasher (
	input logic clk,
	input logic arst_n,
	input logic absorb,
	input logic restart,
	input logic [7:0] char_byte,
	output logic [shtl_pkg::HASH_W-1:0] hash_now
);
	import shtl_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [ROT_W-1:0] rot_q;
	logic ended_q;
	logic take;

	// a zero byte ends the key; nothing after it is hashed
	assign take = absorb && !ended_q && (char_byte != 8'd0);
	assign hash_now = take ? (hash_q ^ rotl32({24'd0, char_byte}, rot_q)) : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			rot_q <= '0;
			ended_q <= 1'b0;
		end else if (restart) begin
			hash_q <= '0;
			rot_q <= '0;
			ended_q <= 1'b0;
		end else if (absorb && !ended_q) begin
			if (char_byte == 8'd0) begin
				ended_q <= 1'b1;
			end else begin
				hash_q <= hash_now;
				rot_q <= rot_q + ROT_STEP;
			end
		end
	end

endmodule

// ===== src/shtl_cell.sv =====
module shtl_cell #(
	parameter int IDX = 0,
	parameter int CW = 9
) (
	input logic clk,
	input logic arst_n,
	input logic [CW-1:0] count,
	input logic wr_en,
	input logic [CW-1:0] wr_idx,
	input logic [shtl_pkg::HASH_W-1:0] wr_hash,
	input shtl_pkg::query_t q_in,
	output shtl_pkg::query_t q_out
);
	import shtl_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [HASH_W-1:0] entry_q;
	query_t q_q;
	query_t q_next;
	logic hit;

	// entry is live only below the fill count
	assign hit = q_in.valid && !q_in.found && (MY_IDX < count) && (entry_q == q_in.hash);

	always_comb begin
		q_next = q_in;
		if (hit) begin
			q_next.found = 1'b1;
			q_next.idx = IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == MY_IDX)) begin
			entry_q <= wr_hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else begin
			q_q <= q_next;
		end
	end

	assign q_out = q_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import shtl_pkg::*;

	localparam int TB_ENTRIES = 256;
	localparam int RAND_ITEMS = 1800;
	// generous guard: every item a full-row lookup, several times over
	localparam int CYCLE_LIMIT = 3_000_000;
	// action code the block ignores
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// one command item, or a marker that holds the sender until all results are in
	typedef struct packed {
		logic drain;
		logic [1:0] act;
		logic [15:0] cu;
		logic w;
		logic lst;
	} cmd_t;

	// key as up to eight characters
	typedef struct packed {
		logic [3:0] len;
		logic [7:0][15:0] ch;
	} key_t;

	typedef struct packed {
		status_t st;
		logic [7:0] idx;
		logic [31:0] hash;
		logic wide;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] action = ACT_CLEAR;
	logic [15:0] char_unit = '0;
	logic wide = 1'b0;
	logic last = 1'b0;
	logic busy;
	logic done;
	status_t status;
	logic [7:0] match_index;
	logic [31:0] key_hash;
	logic wide_out;

	// stimulus side
	cmd_t cmd_q[$];
	key_t key_pool[$];	// keys believed stored, oldest first
	int gen_fill = 0;
	int n_items = 0;
	int sent = 0;
	logic took = 1'b0;	// item presented last cycle was taken

	// hash table shadow
	logic [31:0] key_acc = '0;
	logic [4:0] key_rot = '0;
	logic key_done = 1'b0;
	logic [31:0] stored[TB_ENTRIES];
	int fill = 0;
	reply_t due_replies[$];

	int mismatches = 0;
	int cycles = 0;

	string_hash_table_lookup #(
		.ENTRIES(TB_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.char_unit(char_unit),
		.wide(wide),
		.last(last),
		.done(done),
		.status(status),
		.match_index(match_index),
		.key_hash(key_hash),
		.wide_out(wide_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
	endtask

	// Shadow of the block for one taken item; queues a reply on a last character.
	task automatic hash_table_step(input logic [1:0] act, input logic [15:0] cu,
			input logic w, input logic lst);
		logic [31:0] b;
		reply_t r;
		if (act == ACT_CLEAR) begin
			fill = 0;
			key_acc = '0;
			key_rot = '0;
			key_done = 1'b0;
		end else if (act != ACT_UNUSED) begin
			// zero low byte closes the key; later characters are dropped
			if (!key_done) begin
				if (cu[7:0] == 8'd0) begin
					key_done = 1'b1;
				end else begin
					b = {24'd0, cu[7:0]};
					key_acc ^= (key_rot == 5'd0) ? b :
						((b << key_rot) | (b >> (6'd32 - {1'b0, key_rot})));
					key_rot += ROT_STEP;
				end
			end
			if (lst) begin
				r.hash = key_acc;
				r.wide = w;
				r.idx = '0;
				if (act == ACT_INSERT) begin
					if (fill < TB_ENTRIES) begin
						stored[fill] = key_acc;
						r.idx = fill[7:0];
						fill++;
						r.st = ST_INSERTED;
					end else begin
						r.st = ST_FULL;
					end
				end else begin
					// walk down so the lowest matching index wins
					r.st = ST_MISSING;
					for (int i = fill - 1; i >= 0; i--) begin
						if (stored[i] == key_acc) begin
							r.st = ST_FOUND;
							r.idx = i[7:0];
						end
					end
				end
				due_replies.push_back(r);
				key_acc = '0;
				key_rot = '0;
				key_done = 1'b0;
			end
		end
	endtask

	// Check results, then shadow the item taken at this edge.
	always @(posedge clk) begin : check_and_predict
		reply_t want;
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (due_replies.size() == 0) begin
					report_mismatch("result with nothing due, key_hash", key_hash, '0);
				end else begin
					want = due_replies.pop_front();
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (match_index !== want.idx)
						report_mismatch("match_index", 32'(match_index), 32'(want.idx));
					if (key_hash !== want.hash)
						report_mismatch("key_hash", key_hash, want.hash);
					if (wide_out !== want.wide)
						report_mismatch("wide_out", 32'(wide_out), 32'(want.wide));
				end
			end
			if (start && !busy)
				hash_table_step(action, char_unit, wide, last);
		end
	end

	// Sender: holds an item until taken, idles at random except in a calm stretch,
	// and stops at a drain marker until every due result has come back.
	always @(negedge clk) begin : drive
		cmd_t nxt;
		if (arst_n && !(start && !took)) begin
			if (cmd_q.size() == 0) begin
				start <= 1'b0;
			end else if (cmd_q[0].drain) begin
				start <= 1'b0;
				if (due_replies.size() == 0)
					void'(cmd_q.pop_front());
			end else if (!(sent >= 500 && sent < 800) && $urandom_range(0, 99) < 21) begin
				start <= 1'b0;
			end else begin
				nxt = cmd_q.pop_front();
				start <= 1'b1;
				action <= nxt.act;
				char_unit <= nxt.cu;
				wide <= nxt.w;
				last <= nxt.lst;
				sent++;
			end
		end
	end

	task automatic push_cmd(input logic [1:0] a, input logic [15:0] c, input logic w,
			input logic l);
		cmd_t x;
		x.drain = 1'b0;
		x.act = a;
		x.cu = c;
		x.w = w;
		x.lst = l;
		cmd_q.push_back(x);
		if (a != ACT_UNUSED)
			n_items++;
	endtask

	task automatic push_drain();
		cmd_t x;
		x = '0;
		x.drain = 1'b1;
		cmd_q.push_back(x);
	endtask

	function automatic key_t rand_key();
		key_t k;
		k.len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 8)) :
			4'($urandom_range(1, 4));
		for (int i = 0; i < 8; i++) begin
			k.ch[i] = 16'($urandom);
			if ($urandom_range(0, 11) == 0)
				k.ch[i][7:0] = 8'd0;
		end
		return k;
	endfunction

	// High bytes and anything after a zero byte are fresh each time: they must not
	// change the hash. With close low the key is left open (broken sequence).
	task automatic emit_key(input key_t k, input logic [1:0] act, input bit mix,
			input bit close);
		logic [15:0] c;
		logic [1:0] a;
		bit gone;
		gone = 1'b0;
		for (int i = 0; i < int'(k.len); i++) begin
			c = k.ch[i];
			c[15:8] = 8'($urandom);
			if (gone)
				c = 16'($urandom);
			else if (c[7:0] == 8'd0)
				gone = 1'b1;
			a = act;
			if (mix && i != int'(k.len) - 1)
				a = $urandom_range(0, 1) ? ACT_INSERT : ACT_LOOKUP;
			if ($urandom_range(0, 19) == 0)
				push_cmd(ACT_UNUSED, 16'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			push_cmd(a, c, 1'($urandom_range(0, 1)), close && i == int'(k.len) - 1);
		end
	endtask

	task automatic fill_to_full();
		key_t k;
		push_cmd(ACT_CLEAR, 16'($urandom), 1'b0, 1'b0);
		key_pool.delete();
		gen_fill = 0;
		for (int i = 0; i < TB_ENTRIES + 3; i++) begin
			k = rand_key();
			k.len = 4'($urandom_range(1, 2));
			emit_key(k, ACT_INSERT, 1'b0, 1'b1);	// the last few hit a full table
			if (gen_fill < TB_ENTRIES) begin
				key_pool.push_back(k);
				gen_fill++;
			end
		end
		emit_key(key_pool[TB_ENTRIES - 1], ACT_LOOKUP, 1'b0, 1'b1);
		emit_key(key_pool[0], ACT_LOOKUP, 1'b1, 1'b1);
		emit_key(key_pool[TB_ENTRIES / 2], ACT_LOOKUP, 1'b0, 1'b1);
		emit_key(rand_key(), ACT_LOOKUP, 1'b0, 1'b1);
	endtask

	initial begin : stimulus
		key_t k;
		int pick;
		bit filled;
		filled = 1'b0;

		// --- directed ---
		push_cmd(ACT_INSERT, 16'h0041, 1'b0, 1'b1);	// idx 0
		push_cmd(ACT_INSERT, 16'hFFFF, 1'b1, 1'b0);
		push_cmd(ACT_INSERT, 16'hFF80, 1'b1, 1'b1);	// idx 1
		push_cmd(ACT_INSERT, 16'hFF00, 1'b0, 1'b1);	// zero byte first: hash 0, idx 2
		push_cmd(ACT_LOOKUP, 16'h0000, 1'b1, 1'b1);	// empty key finds idx 2
		push_cmd(ACT_INSERT, 16'h0101, 1'b0, 1'b0);	// zero byte mid key
		push_cmd(ACT_INSERT, 16'h8000, 1'b1, 1'b0);
		push_cmd(ACT_INSERT, 16'h7F7F, 1'b0, 1'b1);
		push_cmd(ACT_LOOKUP, 16'h1241, 1'b1, 1'b1);	// found idx 0
		push_cmd(ACT_LOOKUP, 16'h0002, 1'b0, 1'b1);	// missing
		push_cmd(ACT_INSERT, 16'h00FF, 1'b0, 1'b0);	// mixed actions, lookup decides
		push_cmd(ACT_LOOKUP, 16'h7780, 1'b1, 1'b1);
		push_cmd(ACT_INSERT, 16'h0041, 1'b0, 1'b0);
		push_cmd(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1);	// ignored mid key
		push_cmd(ACT_INSERT, 16'h0042, 1'b1, 1'b1);
		push_cmd(ACT_INSERT, 16'h0055, 1'b0, 1'b0);
		push_cmd(ACT_CLEAR, 16'hFFFF, 1'b1, 1'b1);	// clear drops partial key
		push_cmd(ACT_LOOKUP, 16'h0041, 1'b0, 1'b1);	// table empty: missing
		for (int i = 0; i < 8; i++)	// rotation wraps past 31
			push_cmd(ACT_INSERT, 16'h00FF, i[0], i == 7);
		push_drain();

		// --- random ---
		n_items = 0;
		while (n_items < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				if (key_pool.size() != 0 && $urandom_range(0, 5) == 0)
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];	// duplicate
				else
					k = rand_key();
				emit_key(k, ACT_INSERT, $urandom_range(0, 4) == 0, 1'b1);
				if (gen_fill < TB_ENTRIES) begin
					key_pool.push_back(k);
					gen_fill++;
				end
			end else if (pick < 65 && key_pool.size() != 0) begin
				emit_key(key_pool[$urandom_range(0, key_pool.size() - 1)], ACT_LOOKUP,
					$urandom_range(0, 4) == 0, 1'b1);
			end else if (pick < 82) begin
				emit_key(rand_key(), ACT_LOOKUP, $urandom_range(0, 4) == 0, 1'b1);
			end else if (pick < 86) begin
				push_cmd(ACT_CLEAR, 16'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				key_pool.delete();
				gen_fill = 0;
			end else if (pick < 90) begin
				// open key cut short by a clear
				emit_key(rand_key(), $urandom_range(0, 1) ? ACT_INSERT : ACT_LOOKUP,
					1'b1, 1'b0);
				push_cmd(ACT_CLEAR, 16'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				key_pool.delete();
				gen_fill = 0;
			end else if (pick < 93) begin
				push_drain();
			end else begin
				repeat ($urandom_range(1, 3))
					push_cmd(ACT_UNUSED, 16'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
			if (!filled && n_items > 700) begin
				fill_to_full();
				filled = 1'b1;
			end
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start)
			@(posedge clk);
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (TB_ENTRIES + 8) @(posedge clk);	// catch stray results

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
